[rtl/mbde_pkg.sv]
`timescale 1ns / 1ps

package mbde_pkg;

  // Default highest total degree of the basis.
  localparam int MAX_ORDER_DEF = 8;

  // Widths that cover the whole supported range of the highest degree (up to 12).
  localparam int EXP_W  = 4;   // exponents, degrees and factor counts
  localparam int I2_W   = 7;   // offset of an index within its degree
  localparam int COEF_W = 8;   // derivative coefficient, at most 12 * 11
  localparam int D_W    = 33;  // offset from the centroid, Q16.16 with one guard bit

  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_SECOND = 2'd2;

  localparam logic [2:0] DIR_X  = 3'd0;
  localparam logic [2:0] DIR_Y  = 3'd1;
  localparam logic [2:0] DIR_Z  = 3'd2;
  localparam logic [2:0] DIR_XX = 3'd0;
  localparam logic [2:0] DIR_XY = 3'd1;
  localparam logic [2:0] DIR_YY = 3'd2;
  localparam logic [2:0] DIR_XZ = 3'd3;
  localparam logic [2:0] DIR_YZ = 3'd4;
  localparam logic [2:0] DIR_ZZ = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SEL = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Number of monomials of total degree below n in three variables.
  function automatic int tet(input int n);
    return (n * (n + 1) * (n + 2)) / 6;
  endfunction

  // Per-item information that travels alongside the product.
  typedef struct packed {
    logic [1:0]        status;
    logic [EXP_W-1:0]  ex;
    logic [EXP_W-1:0]  ey;
    logic [EXP_W-1:0]  ez;
    logic [EXP_W-1:0]  k;
    logic [COEF_W-1:0] coef;
    logic              neg;
    logic              zero;
    logic [D_W-1:0]    mx;
    logic [D_W-1:0]    my;
    logic [D_W-1:0]    mz;
  } side_t;

endpackage

[rtl/monomial_basis_derivative_eval.sv]
`timescale 1ns / 1ps
// Each accepted input passes through stages 0, 1 and 2, the partial-product and addition stage
// of every multiply slot, then final stages 1 and 2; final stage 2 registers the result.
// Throughput: one transaction per cycle while the output side is ready; one result per input.
// Reset: rst_ni is asynchronous and active low; it clears every stage valid bit, so the
// pipeline comes out of reset empty. Data registers are not reset.

module monomial_basis_derivative_eval #(
  parameter int MAX_ORDER = mbde_pkg::MAX_ORDER_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: basis_index[7:0], point_x[39:8], point_y[71:40],
  // point_z[103:72], center_x[135:104], center_y[167:136], center_z[199:168].
  input  logic [199:0] s_axis_tdata,
  // Fields from bit 0 up: kind[1:0], direction[4:2].
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0 up: result_value[63:0].
  output logic [63:0]  m_axis_tdata,
  // Fields from bit 0 up: status[1:0].
  output logic [1:0]   m_axis_tuser
);

  localparam int EW = mbde_pkg::EXP_W;
  localparam int DW = mbde_pkg::D_W;

  // The running product is kept exactly up to L bits. Any product at or above 2^L is
  // certain to saturate for every factor count, so a sticky overflow flag takes over.
  localparam int L   = 16 * (MAX_ORDER - 2) + 66;
  // The product is cut into 33-bit chunks, each multiplied by the 33-bit factor. The
  // 66-bit partial products of even chunks do not overlap, nor do those of odd chunks,
  // so one wide addition of two words finishes each multiplication.
  localparam int NCH = (L + 32) / 33;
  localparam int PW  = 33 * NCH;
  localparam int SW  = 33 * (NCH + 1);

  // The whole pipeline moves together; it halts only while a finished result waits.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 0: selector and range checks, total degree, offsets from the centroid.
  // ---------------------------------------------------------------------------
  logic [1:0]           in_kind;
  logic [2:0]           in_dir;
  logic [7:0]           in_idx;
  logic [1:0]           s0_status_d;
  logic [EW-1:0]        s0_o_d;
  logic [mbde_pkg::I2_W-1:0] s0_i2_d;
  logic signed [DW-1:0] s0_dx_d, s0_dy_d, s0_dz_d;
  int                   tsel;

  assign in_kind = s_axis_tuser[1:0];
  assign in_dir  = s_axis_tuser[4:2];
  assign in_idx  = s_axis_tdata[7:0];

  always_comb begin
    s0_status_d = mbde_pkg::ST_OK;
    if ((in_kind != mbde_pkg::KIND_VALUE && in_kind != mbde_pkg::KIND_FIRST &&
         in_kind != mbde_pkg::KIND_SECOND) ||
        (in_kind == mbde_pkg::KIND_FIRST && in_dir > mbde_pkg::DIR_Z) ||
        (in_kind == mbde_pkg::KIND_SECOND && in_dir > mbde_pkg::DIR_ZZ)) begin
      s0_status_d = mbde_pkg::ST_BAD_SEL;
    end else if (int'(in_idx) >= mbde_pkg::tet(MAX_ORDER + 1)) begin
      s0_status_d = mbde_pkg::ST_RANGE;
    end
    // The degree is the number of degree boundaries at or below the index.
    s0_o_d = '0;
    for (int n = 1; n <= MAX_ORDER; n++) begin
      if (int'(in_idx) >= mbde_pkg::tet(n)) begin
        s0_o_d = s0_o_d + EW'(1);
      end
    end
    tsel = 0;
    for (int n = 0; n <= MAX_ORDER; n++) begin
      if (s0_o_d == EW'(n)) begin
        tsel = mbde_pkg::tet(n);
      end
    end
    s0_i2_d = mbde_pkg::I2_W'(int'(in_idx) - tsel);
    s0_dx_d = DW'($signed(s_axis_tdata[39:8]))    - DW'($signed(s_axis_tdata[135:104]));
    s0_dy_d = DW'($signed(s_axis_tdata[71:40]))   - DW'($signed(s_axis_tdata[167:136]));
    s0_dz_d = DW'($signed(s_axis_tdata[103:72]))  - DW'($signed(s_axis_tdata[199:168]));
  end

  logic                 s0_v_q;
  logic [1:0]           s0_status_q, s0_kind_q;
  logic [2:0]           s0_dir_q;
  logic [EW-1:0]        s0_o_q;
  logic [mbde_pkg::I2_W-1:0] s0_i2_q;
  logic signed [DW-1:0] s0_dx_q, s0_dy_q, s0_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_status_q <= s0_status_d;
      s0_kind_q   <= in_kind;
      s0_dir_q    <= in_dir;
      s0_o_q      <= s0_o_d;
      s0_i2_q     <= s0_i2_d;
      s0_dx_q     <= s0_dx_d;
      s0_dy_q     <= s0_dy_d;
      s0_dz_q     <= s0_dz_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: exponents. Within degree o the group of z exponent j starts at
  // j*(o+1) - j*(j-1)/2, and the x exponent falls from the start of the group.
  // ---------------------------------------------------------------------------
  logic [EW-1:0] s1_ex_d, s1_ey_d, s1_ez_d;
  int            s1_o, s1_i2, s1_sj, s1_snext;

  always_comb begin
    s1_o     = int'(s0_o_q);
    s1_i2    = int'(s0_i2_q);
    s1_ez_d  = '0;
    s1_snext = 0;
    for (int j = 1; j <= MAX_ORDER; j++) begin
      s1_sj = j * (s1_o + 1) - (j * (j - 1)) / 2;
      if (j <= s1_o && s1_sj <= s1_i2) begin
        s1_ez_d = s1_ez_d + EW'(1);
      end
    end
    for (int j = 1; j <= MAX_ORDER + 1; j++) begin
      if (int'(s1_ez_d) + 1 == j) begin
        s1_snext = j * (s1_o + 1) - (j * (j - 1)) / 2;
      end
    end
    s1_ex_d = EW'(s1_snext - 1 - s1_i2);
    s1_ey_d = s0_o_q - s1_ex_d - s1_ez_d;
  end

  logic                 s1_v_q;
  logic [1:0]           s1_status_q, s1_kind_q;
  logic [2:0]           s1_dir_q;
  logic [EW-1:0]        s1_ex_q, s1_ey_q, s1_ez_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_status_q <= s0_status_q;
      s1_kind_q   <= s0_kind_q;
      s1_dir_q    <= s0_dir_q;
      s1_ex_q     <= s1_ex_d;
      s1_ey_q     <= s1_ey_d;
      s1_ez_q     <= s1_ez_d;
      s1_dx_q     <= s0_dx_q;
      s1_dy_q     <= s0_dy_q;
      s1_dz_q     <= s0_dz_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: derivative coefficient and reduced exponents, sign, magnitudes.
  // ---------------------------------------------------------------------------
  function automatic logic [EW-1:0] dec1(input logic [EW-1:0] e);
    return (e != '0) ? e - EW'(1) : '0;
  endfunction

  function automatic logic [mbde_pkg::COEF_W-1:0] same2(input logic [EW-1:0] e);
    return (e != '0) ? mbde_pkg::COEF_W'(e) * mbde_pkg::COEF_W'(e - EW'(1)) : '0;
  endfunction

  function automatic logic [EW-1:0] dec2(input logic [EW-1:0] e);
    return (e >= EW'(2)) ? e - EW'(2) : '0;
  endfunction

  function automatic logic [mbde_pkg::COEF_W-1:0] cross2(input logic [EW-1:0] a,
                                                         input logic [EW-1:0] b);
    return mbde_pkg::COEF_W'(a) * mbde_pkg::COEF_W'(b);
  endfunction

  mbde_pkg::side_t s2_d;

  always_comb begin
    s2_d.status = s1_status_q;
    s2_d.ex     = s1_ex_q;
    s2_d.ey     = s1_ey_q;
    s2_d.ez     = s1_ez_q;
    s2_d.coef   = mbde_pkg::COEF_W'(1);
    case (s1_kind_q)
      mbde_pkg::KIND_FIRST: begin
        case (s1_dir_q)
          mbde_pkg::DIR_X: begin
            s2_d.coef = mbde_pkg::COEF_W'(s1_ex_q);
            s2_d.ex   = dec1(s1_ex_q);
          end
          mbde_pkg::DIR_Y: begin
            s2_d.coef = mbde_pkg::COEF_W'(s1_ey_q);
            s2_d.ey   = dec1(s1_ey_q);
          end
          mbde_pkg::DIR_Z: begin
            s2_d.coef = mbde_pkg::COEF_W'(s1_ez_q);
            s2_d.ez   = dec1(s1_ez_q);
          end
          default: s2_d.coef = '0;
        endcase
      end
      mbde_pkg::KIND_SECOND: begin
        case (s1_dir_q)
          mbde_pkg::DIR_XX: begin
            s2_d.coef = same2(s1_ex_q);
            s2_d.ex   = dec2(s1_ex_q);
          end
          mbde_pkg::DIR_XY: begin
            s2_d.coef = cross2(s1_ex_q, s1_ey_q);
            s2_d.ex   = dec1(s1_ex_q);
            s2_d.ey   = dec1(s1_ey_q);
          end
          mbde_pkg::DIR_YY: begin
            s2_d.coef = same2(s1_ey_q);
            s2_d.ey   = dec2(s1_ey_q);
          end
          mbde_pkg::DIR_XZ: begin
            s2_d.coef = cross2(s1_ex_q, s1_ez_q);
            s2_d.ex   = dec1(s1_ex_q);
            s2_d.ez   = dec1(s1_ez_q);
          end
          mbde_pkg::DIR_YZ: begin
            s2_d.coef = cross2(s1_ey_q, s1_ez_q);
            s2_d.ey   = dec1(s1_ey_q);
            s2_d.ez   = dec1(s1_ez_q);
          end
          mbde_pkg::DIR_ZZ: begin
            s2_d.coef = same2(s1_ez_q);
            s2_d.ez   = dec2(s1_ez_q);
          end
          default: s2_d.coef = '0;
        endcase
      end
      default: s2_d.coef = mbde_pkg::COEF_W'(1);
    endcase
    s2_d.k    = s2_d.ex + s2_d.ey + s2_d.ez;
    // A vanishing coefficient or a zero offset raised to a positive power gives zero.
    s2_d.zero = (s2_d.coef == '0) ||
                (s2_d.ex != '0 && s1_dx_q == '0) ||
                (s2_d.ey != '0 && s1_dy_q == '0) ||
                (s2_d.ez != '0 && s1_dz_q == '0);
    s2_d.neg  = (s2_d.ex[0] & s1_dx_q[DW-1]) ^ (s2_d.ey[0] & s1_dy_q[DW-1]) ^
                (s2_d.ez[0] & s1_dz_q[DW-1]);
    s2_d.mx   = s1_dx_q[DW-1] ? DW'(-s1_dx_q) : DW'(s1_dx_q);
    s2_d.my   = s1_dy_q[DW-1] ? DW'(-s1_dy_q) : DW'(s1_dy_q);
    s2_d.mz   = s1_dz_q[DW-1] ? DW'(-s1_dz_q) : DW'(s1_dz_q);
  end

  logic            s2_v_q;
  mbde_pkg::side_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply chain: one slot per possible factor. Slot j multiplies by the
  // magnitude of the j-th factor (x factors first, then y, then z) or by one
  // where the monomial has fewer factors. Each slot is a partial-product stage
  // followed by an addition stage.
  // ---------------------------------------------------------------------------
  logic [MAX_ORDER-1:0] vm_q, va_q;
  logic [MAX_ORDER-1:0] om_q, oa_q;
  logic [65:0]          prod_q [MAX_ORDER][NCH];
  logic [SW-1:0]        pa_q   [MAX_ORDER];
  mbde_pkg::side_t      sm_q   [MAX_ORDER];
  mbde_pkg::side_t      sa_q   [MAX_ORDER];

  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_slot
    logic            in_v;
    logic [SW-1:0]   in_p;
    logic            in_o;
    mbde_pkg::side_t in_s;
    logic [PW-1:0]   pin;
    logic [DW-1:0]   fac;
    logic [EW:0]     exy;
    logic [SW-1:0]   even_w, odd_w;

    if (j == 0) begin : g_first
      assign in_v = s2_v_q;
      assign in_p = SW'(s2_q.coef);
      assign in_o = 1'b0;
      assign in_s = s2_q;
    end else begin : g_next
      assign in_v = va_q[j-1];
      assign in_p = pa_q[j-1];
      assign in_o = oa_q[j-1];
      assign in_s = sa_q[j-1];
    end

    always_comb begin
      pin = PW'(in_p[L-1:0]);
      exy = {1'b0, in_s.ex} + {1'b0, in_s.ey};
      if ((EW+1)'(j) < {1'b0, in_s.ex}) begin
        fac = in_s.mx;
      end else if ((EW+1)'(j) < exy) begin
        fac = in_s.my;
      end else if ((EW+1)'(j) < {1'b0, in_s.k}) begin
        fac = in_s.mz;
      end else begin
        fac = DW'(1);
      end
    end

    always_comb begin
      even_w = '0;
      odd_w  = '0;
      for (int i = 0; i < NCH; i++) begin
        if (i % 2 == 0) begin
          even_w = even_w | (SW'(prod_q[j][i]) << (33 * i));
        end else begin
          odd_w = odd_w | (SW'(prod_q[j][i]) << (33 * i));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q[j] <= 1'b0;
        va_q[j] <= 1'b0;
      end else if (en) begin
        vm_q[j] <= in_v;
        va_q[j] <= vm_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < NCH; i++) begin
          prod_q[j][i] <= 66'(pin[33*i +: 33]) * 66'(fac);
        end
        om_q[j] <= in_o | (|in_p[SW-1:L]);
        sm_q[j] <= in_s;
        pa_q[j] <= even_w + odd_w;
        oa_q[j] <= om_q[j];
        sa_q[j] <= sm_q[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage 1: scale to Q32.32 and pick the rounding bit.
  // ---------------------------------------------------------------------------
  logic [L-1:0]  fp;
  logic [L-1:0]  fq, fr;
  logic          f1_ovf;
  logic [63:0]   f1_v_d;
  logic          f1_rb_d, f1_high_d;
  int            f1_sh;

  always_comb begin
    fp     = pa_q[MAX_ORDER-1][L-1:0];
    f1_ovf = oa_q[MAX_ORDER-1] | (|pa_q[MAX_ORDER-1][SW-1:L]);
    f1_sh  = 16 * (int'(sa_q[MAX_ORDER-1].k) - 2);
    fq     = '0;
    fr     = '0;
    if (sa_q[MAX_ORDER-1].k >= EW'(2)) begin
      fq        = fp >> f1_sh;
      f1_v_d    = fq[63:0];
      f1_high_d = f1_ovf | (|fq[L-1:64]);
      if (sa_q[MAX_ORDER-1].k >= EW'(3)) begin
        fr = fp >> (f1_sh - 1);
      end
      f1_rb_d = fr[0];
    end else begin
      f1_v_d    = fp[63:0] << (-f1_sh);
      f1_high_d = f1_ovf;
      f1_rb_d   = 1'b0;
    end
  end

  logic            f1_v_q;
  logic [63:0]     f1_val_q;
  logic            f1_rb_q, f1_high_q;
  mbde_pkg::side_t f1_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= va_q[MAX_ORDER-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_val_q  <= f1_v_d;
      f1_rb_q   <= f1_rb_d;
      f1_high_q <= f1_high_d;
      f1_s_q    <= sa_q[MAX_ORDER-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage 2: round half away from zero on the magnitude, apply the sign,
  // saturate, and register the result.
  // ---------------------------------------------------------------------------
  logic [64:0] f2_sum;
  logic        f2_high;
  logic [63:0] res_d;
  logic [1:0]  st_d;

  always_comb begin
    f2_sum  = {1'b0, f1_val_q} + 65'(f1_rb_q);
    f2_high = f1_high_q | f2_sum[64];
    res_d   = '0;
    st_d    = f1_s_q.status;
    if (f1_s_q.status != mbde_pkg::ST_OK || f1_s_q.zero) begin
      res_d = '0;
    end else if (f1_s_q.neg) begin
      if (f2_high || f2_sum[63:0] > 64'h8000_0000_0000_0000) begin
        res_d = 64'h8000_0000_0000_0000;
        st_d  = mbde_pkg::ST_SAT;
      end else begin
        res_d = ~f2_sum[63:0] + 64'd1;
      end
    end else begin
      if (f2_high || f2_sum[63]) begin
        res_d = 64'h7FFF_FFFF_FFFF_FFFF;
        st_d  = mbde_pkg::ST_SAT;
      end else begin
        res_d = f2_sum[63:0];
      end
    end
  end

  logic        out_v_q;
  logic [63:0] out_res_q;
  logic [1:0]  out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= res_d;
      out_st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_st_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A saturated result always carries one of the two extreme values.
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == mbde_pkg::ST_SAT) |->
    (m_axis_tdata == 64'h7FFF_FFFF_FFFF_FFFF || m_axis_tdata == 64'h8000_0000_0000_0000))
    else $error("saturated result is not an extreme value");

  // A rejected selector or index always comes out as zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == mbde_pkg::ST_BAD_SEL ||
                       m_axis_tuser == mbde_pkg::ST_RANGE)) |-> (m_axis_tdata == '0))
    else $error("rejected transaction gives a non-zero result");

  // While the output is held, the valid bits of the multiply slots and of final stage 1 must not change.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(va_q) && $stable(f1_v_q))
    else $error("pipeline moved while the output was stalled");

endmodule
